// ----- rtl/core/acm_pkg.sv -----
// Shared types, constants and the control store of the accumulator machine core.
// Depends on nothing; used by accumulator_machine_core.
`default_nettype none

package acm_pkg;

    // Field widths of the stream beats
    localparam int WORD_W     = 64;
    localparam int WADDR_W    = 12;
    localparam int IN_VAL_W   = 32;
    localparam int PC_OUT_W   = 12;
    localparam int S_TDATA_W  = 112;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 144;
    localparam int M_TUSER_W  = 5;

    localparam int MEM_WORDS_DEF = 4096;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_EXEC    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        OP_STOP = 4'd0,
        OP_GET  = 4'd1,
        OP_PUT  = 4'd2,
        OP_LD   = 4'd3,
        OP_ST   = 4'd4,
        OP_ADD  = 4'd5,
        OP_SUB  = 4'd6,
        OP_JPOS = 4'd7,
        OP_JZ   = 4'd8,
        OP_JMP  = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_OPCODE = 2'd1,
        FLT_RANGE  = 2'd2
    } fault_t;

    // Micro-program addresses
    typedef enum logic [2:0] {
        UP_CLEAR     = 3'd0,
        UP_IDLE      = 3'd1,
        UP_FETCH_AD  = 3'd2,
        UP_READ_OPND = 3'd3,
        UP_EXEC      = 3'd4,
        UP_WRITE     = 3'd5,
        UP_RESTART   = 3'd6,
        UP_REPORT    = 3'd7
    } upc_t;

    // Sequencer jump conditions
    typedef enum logic [1:0] {
        C_GOTO     = 2'd0,
        C_CLR_MORE = 2'd1,
        C_DISPATCH = 2'd2
    } cond_t;

    // Memory address source
    typedef enum logic [2:0] {
        MA_PC    = 3'd0,
        MA_PC1   = 3'd1,
        MA_OPND  = 3'd2,
        MA_ADDR  = 3'd3,
        MA_WADDR = 3'd4,
        MA_CLR   = 3'd5
    } msel_t;

    // Memory write data source
    typedef enum logic [1:0] {
        WS_ZERO = 2'd0,
        WS_REQ  = 2'd1,
        WS_ACC  = 2'd2
    } wsel_t;

    // Architectural state update
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_EXEC    = 2'd1,
        ACT_RESTART = 2'd2
    } act_t;

    typedef struct packed {
        cond_t  cond;
        upc_t   target;
        msel_t  msel;
        logic   mem_we;
        wsel_t  wsel;
        logic   ld_op;
        logic   ld_addr;
        act_t   act;
        logic   emit;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input upc_t upc);
        ctrl_word_t cw;
        cw.cond    = C_GOTO;
        cw.target  = UP_IDLE;
        cw.msel    = MA_PC;
        cw.mem_we  = 1'b0;
        cw.wsel    = WS_ZERO;
        cw.ld_op   = 1'b0;
        cw.ld_addr = 1'b0;
        cw.act     = ACT_NONE;
        cw.emit    = 1'b0;
        case (upc)
            UP_CLEAR:
            begin
                cw.cond   = C_CLR_MORE;
                cw.msel   = MA_CLR;
                cw.mem_we = 1'b1;
            end
            UP_IDLE:
            begin
                cw.cond = C_DISPATCH;
            end
            UP_FETCH_AD:
            begin
                cw.target = UP_READ_OPND;
                cw.msel   = MA_PC1;
                cw.ld_op  = 1'b1;
            end
            UP_READ_OPND:
            begin
                cw.target  = UP_EXEC;
                cw.msel    = MA_OPND;
                cw.ld_addr = 1'b1;
            end
            UP_EXEC:
            begin
                cw.msel   = MA_ADDR;
                cw.mem_we = 1'b1;
                cw.wsel   = WS_ACC;
                cw.act    = ACT_EXEC;
                cw.emit   = 1'b1;
            end
            UP_WRITE:
            begin
                cw.msel   = MA_WADDR;
                cw.mem_we = 1'b1;
                cw.wsel   = WS_REQ;
                cw.emit   = 1'b1;
            end
            UP_RESTART:
            begin
                cw.act  = ACT_RESTART;
                cw.emit = 1'b1;
            end
            UP_REPORT:
            begin
                cw.emit = 1'b1;
            end
            default:
            begin
                cw.target = UP_IDLE;
            end
        endcase
        return cw;
    endfunction

    // Entry point of the micro-program for an accepted request
    function automatic upc_t dispatch(input req_t req, input logic stopped);
        upc_t target;
        case (req)
            REQ_WRITE:   target = UP_WRITE;
            REQ_RESTART: target = UP_RESTART;
            REQ_EXEC:    target = stopped ? UP_REPORT : UP_FETCH_AD;
            default:     target = UP_REPORT;
        endcase
        return target;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/accumulator_machine_core.sv -----
// Accumulator machine core: microcoded sequencer, single-port word memory, stream ports.
// Depends on acm_pkg for types, constants and the control store.
`default_nettype none

// Word-addressed accumulator machine. Each input beat is one request: write a memory
// word, execute one instruction, or restart pc and accumulator; each request returns
// exactly one result beat with the state after it. Code and data share one memory of
// MEM_WORDS 64-bit words on a single port. After reset a clearing pass writes zero to
// every word, one word a cycle, so no beat is accepted until that pass ends. An execute
// request passes through the idle step that accepts it, then FETCH_AD, READ_OPND and
// EXEC, and its result beat is registered from EXEC: the single memory port is used
// in turn for the opcode word, the address word, the operand and the store. Writes,
// restarts and other requests go from the accepting idle step to their own WRITE,
// RESTART or REPORT step, which registers the result. A result is held in an output
// register; the next request is taken while it waits, and the final step of that
// request stalls until the register is free.
module accumulator_machine_core #(
    parameter int MEM_WORDS = acm_pkg::MEM_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // word_addr[11:0], word_data[75:12], in_value[107:76], zero pad
    input  wire logic [acm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[1:0], in_eof[2]
    input  wire logic [acm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // put_value[63:0], pc_now[75:64], acc_now[139:76], zero pad
    output logic [acm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // put_valid[0], took_input[1], halted[2], fault[4:3]
    output logic [acm_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    localparam int AW    = $clog2(MEM_WORDS);
    localparam int WW    = acm_pkg::WORD_W;
    localparam int WAW   = acm_pkg::WADDR_W;
    localparam int IVW   = acm_pkg::IN_VAL_W;
    localparam int PCW   = acm_pkg::PC_OUT_W;
    localparam int M_PAD = acm_pkg::M_TDATA_W - (2 * WW + PCW);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

    // Sequencer
    acm_pkg::upc_t       upc_reg, upc_next;
    acm_pkg::ctrl_word_t cw;
    logic                stall;
    logic                accept;
    logic                out_free;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;

    // Architectural state
    logic [AW-1:0]       pc_reg, pc_next;
    logic [WW-1:0]       acc_reg, acc_next;
    logic                stopped_reg, stopped_next;
    acm_pkg::fault_t     fault_reg, fault_next;

    // Request and instruction holding registers
    logic [WAW-1:0]      waddr_reg;
    logic [WW-1:0]       wdata_reg;
    logic [IVW-1:0]      in_value_reg;
    logic                eof_reg;
    acm_pkg::opcode_t    op_reg;
    logic                op_bad_reg;
    logic [WW-1:0]       addr_reg;

    // Memory port
    logic [WW-1:0]       mem [MEM_WORDS];
    logic [WW-1:0]       mem_rdata_reg;
    logic [AW-1:0]       mem_addr;
    logic [WW-1:0]       mem_wdata;
    logic                mem_we;

    // Execute outcome
    logic                pc1_ok;
    logic                next_ok;
    logic                addr_ok;
    logic                waddr_ok;
    logic                ex_halt;
    acm_pkg::fault_t     ex_fault;
    logic [AW-1:0]       ex_pc;
    logic [WW-1:0]       ex_acc;
    logic                ex_put;
    logic                ex_took;
    logic                ex_store;
    logic                ex_seq;
    logic                ex_taken;

    // Result register
    logic                out_valid_reg;
    logic                put_valid_reg;
    logic [WW-1:0]       put_value_reg;
    logic                took_reg;
    logic                halted_reg;
    acm_pkg::fault_t     fault_out_reg;
    logic [PCW-1:0]      pc_now_reg;
    logic [WW-1:0]       acc_now_reg;

    assign cw            = acm_pkg::ucode_rom(upc_reg);
    assign s_axis_tready = (upc_reg == acm_pkg::UP_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stall         = cw.emit && !out_free;

    assign pc1_ok   = (32'(pc_reg) + 32'd1) < 32'(MEM_WORDS);
    assign next_ok  = (32'(pc_reg) + 32'd2) < 32'(MEM_WORDS);
    assign addr_ok  = addr_reg < 64'(MEM_WORDS);
    assign waddr_ok = 32'(waddr_reg) < 32'(MEM_WORDS);

    // Next micro-step
    always_comb
    begin
        upc_next = upc_reg;
        if (!stall)
        begin
            case (cw.cond)
                acm_pkg::C_GOTO:
                    upc_next = cw.target;
                acm_pkg::C_CLR_MORE:
                    if (clr_cnt_reg == CLR_LAST)
                        upc_next = cw.target;
                acm_pkg::C_DISPATCH:
                    if (accept)
                        upc_next = acm_pkg::dispatch(acm_pkg::req_t'(s_axis_tuser[1:0]),
                                                     stopped_reg);
                default:
                    upc_next = cw.target;
            endcase
        end
    end

    assign clr_cnt_next = (cw.msel == acm_pkg::MA_CLR) ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    // Instruction execution
    always_comb
    begin
        ex_halt  = 1'b0;
        ex_fault = acm_pkg::FLT_NONE;
        ex_pc    = pc_reg;
        ex_acc   = acc_reg;
        ex_put   = 1'b0;
        ex_took  = 1'b0;
        ex_store = 1'b0;
        ex_seq   = 1'b0;
        ex_taken = 1'b0;
        if (op_bad_reg)
        begin
            ex_halt  = 1'b1;
            ex_fault = acm_pkg::FLT_OPCODE;
        end
        else
        begin
            case (op_reg)
                acm_pkg::OP_STOP:
                    ex_halt = 1'b1;
                acm_pkg::OP_GET:
                begin
                    if (eof_reg)
                        ex_halt = 1'b1;
                    else
                    begin
                        ex_acc  = {{(WW - IVW){in_value_reg[IVW-1]}}, in_value_reg};
                        ex_took = 1'b1;
                        ex_seq  = 1'b1;
                    end
                end
                acm_pkg::OP_PUT:
                begin
                    ex_put = 1'b1;
                    ex_seq = 1'b1;
                end
                acm_pkg::OP_LD, acm_pkg::OP_ST, acm_pkg::OP_ADD, acm_pkg::OP_SUB:
                begin
                    if (!addr_ok)
                    begin
                        ex_halt  = 1'b1;
                        ex_fault = acm_pkg::FLT_RANGE;
                    end
                    else
                    begin
                        ex_seq = 1'b1;
                        case (op_reg)
                            acm_pkg::OP_LD:  ex_acc = mem_rdata_reg;
                            acm_pkg::OP_ADD: ex_acc = acc_reg + mem_rdata_reg;
                            acm_pkg::OP_SUB: ex_acc = acc_reg - mem_rdata_reg;
                            default:         ex_store = 1'b1;
                        endcase
                    end
                end
                acm_pkg::OP_JPOS, acm_pkg::OP_JZ, acm_pkg::OP_JMP:
                begin
                    case (op_reg)
                        acm_pkg::OP_JPOS: ex_taken = !acc_reg[WW-1] && (acc_reg != '0);
                        acm_pkg::OP_JZ:   ex_taken = (acc_reg == '0);
                        default:          ex_taken = 1'b1;
                    endcase
                    if (!ex_taken)
                        ex_seq = 1'b1;
                    else if (addr_reg[WW-1])
                        ex_halt = 1'b1;
                    else if (!addr_ok)
                    begin
                        ex_halt  = 1'b1;
                        ex_fault = acm_pkg::FLT_RANGE;
                    end
                    else
                        ex_pc = addr_reg[AW-1:0];
                end
                default:
                begin
                    ex_halt  = 1'b1;
                    ex_fault = acm_pkg::FLT_OPCODE;
                end
            endcase
        end
        // Running off the end keeps the instruction's effects but holds pc
        if (ex_seq)
        begin
            if (!next_ok)
            begin
                ex_halt  = 1'b1;
                ex_fault = acm_pkg::FLT_RANGE;
            end
            else
                ex_pc = pc_reg + AW'(2);
        end
    end

    // Architectural state update selected by the control word
    always_comb
    begin
        pc_next      = pc_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        fault_next   = fault_reg;
        case (cw.act)
            acm_pkg::ACT_EXEC:
            begin
                pc_next  = ex_pc;
                acc_next = ex_acc;
                if (ex_halt)
                begin
                    stopped_next = 1'b1;
                    fault_next   = ex_fault;
                end
            end
            acm_pkg::ACT_RESTART:
            begin
                pc_next      = '0;
                acc_next     = '0;
                stopped_next = 1'b0;
                fault_next   = acm_pkg::FLT_NONE;
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    // Memory port controls
    always_comb
    begin
        case (cw.msel)
            acm_pkg::MA_PC:    mem_addr = pc_reg;
            acm_pkg::MA_PC1:   mem_addr = pc_reg + 1'b1;
            acm_pkg::MA_OPND:  mem_addr = pc1_ok ? mem_rdata_reg[AW-1:0] : '0;
            acm_pkg::MA_ADDR:  mem_addr = addr_reg[AW-1:0];
            acm_pkg::MA_WADDR: mem_addr = AW'(waddr_reg);
            acm_pkg::MA_CLR:   mem_addr = clr_cnt_reg;
            default:           mem_addr = pc_reg;
        endcase
        case (cw.wsel)
            acm_pkg::WS_REQ: mem_wdata = wdata_reg;
            acm_pkg::WS_ACC: mem_wdata = acc_reg;
            default:         mem_wdata = '0;
        endcase
        case (cw.msel)
            acm_pkg::MA_WADDR: mem_we = cw.mem_we && !stall && waddr_ok;
            acm_pkg::MA_ADDR:  mem_we = cw.mem_we && !stall && ex_store;
            acm_pkg::MA_CLR:   mem_we = cw.mem_we;
            default:           mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= acm_pkg::UP_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            fault_reg     <= acm_pkg::FLT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg     <= upc_next;
            clr_cnt_reg <= clr_cnt_next;
            if (!stall)
            begin
                pc_reg      <= pc_next;
                acc_reg     <= acc_next;
                stopped_reg <= stopped_next;
                fault_reg   <= fault_next;
            end
            if (cw.emit && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and instruction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            waddr_reg    <= s_axis_tdata[WAW-1:0];
            wdata_reg    <= s_axis_tdata[WAW +: WW];
            in_value_reg <= s_axis_tdata[WAW + WW +: IVW];
            eof_reg      <= s_axis_tuser[2];
        end
        if (cw.ld_op)
        begin
            op_reg     <= acm_pkg::opcode_t'(mem_rdata_reg[3:0]);
            op_bad_reg <= |mem_rdata_reg[WW-1:4];
        end
        if (cw.ld_addr)
            addr_reg <= pc1_ok ? mem_rdata_reg : '0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cw.emit && out_free)
        begin
            put_valid_reg <= (cw.act == acm_pkg::ACT_EXEC) && ex_put;
            put_value_reg <= ((cw.act == acm_pkg::ACT_EXEC) && ex_put) ? acc_reg : '0;
            took_reg      <= (cw.act == acm_pkg::ACT_EXEC) && ex_took;
            halted_reg    <= stopped_next;
            fault_out_reg <= fault_next;
            pc_now_reg    <= PCW'(pc_next);
            acc_now_reg   <= acc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD{1'b0}}, acc_now_reg, pc_now_reg, put_value_reg};
    assign m_axis_tuser  = {fault_out_reg, halted_reg, took_reg, put_valid_reg};

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for accumulator_machine_core: directed and random request streams,
// with a step-by-step model of the machine tracking memory, pc and accumulator.
// Depends on acm_pkg for request, opcode and fault codes and the stream widths.

package acm_check_pkg;

    import acm_pkg::*;

    localparam int MEM_WORDS = MEM_WORDS_DEF;

    typedef struct packed {
        bit          put_valid;
        logic [63:0] put_value;
        bit          took_input;
        bit          halted;
        fault_t      fault;
        logic [11:0] pc_now;
        logic [63:0] acc_now;
    } step_report_t;

    class acm_tracker;
        logic [63:0]  mem [MEM_WORDS];
        logic [63:0]  pc;
        logic [63:0]  acc;
        bit           stopped;
        fault_t       fault_code;
        step_report_t pending_reports [$];
        int unsigned  errors;
        int unsigned  useful_requests;
        int unsigned  instr_count;
        int unsigned  put_count;
        int unsigned  get_count;
        int unsigned  write_count;
        int unsigned  restart_count;
        int unsigned  halt_count [3];

        function new();
            foreach (mem[i])
                mem[i] = '0;
            pc = '0;
            acc = '0;
            stopped = 1'b0;
            fault_code = FLT_NONE;
            errors = 0;
            useful_requests = 0;
            instr_count = 0;
            put_count = 0;
            get_count = 0;
            write_count = 0;
            restart_count = 0;
            foreach (halt_count[i])
                halt_count[i] = 0;
        endfunction

        function void halt(fault_t code);
            stopped = 1'b1;
            fault_code = code;
            halt_count[int'(code)]++;
        endfunction

        // Run one instruction at pc; a halting instruction leaves pc where it is
        function void execute_instruction(logic [63:0] get_val, bit eof, inout step_report_t rep);
            logic [63:0] op_word;
            logic [63:0] opnd;
            logic [63:0] seq_pc;
            bit          taken;
            instr_count++;
            op_word = mem[pc];
            opnd = (pc + 1 < MEM_WORDS) ? mem[pc + 1] : '0;
            seq_pc = pc + 2;
            if (op_word > 64'(OP_JMP))
            begin
                halt(FLT_OPCODE);
                return;
            end
            case (opcode_t'(op_word[3:0]))
                OP_STOP:
                begin
                    halt(FLT_NONE);
                    return;
                end
                OP_GET:
                begin
                    if (eof)
                    begin
                        halt(FLT_NONE);
                        return;
                    end
                    acc = get_val;
                    rep.took_input = 1'b1;
                    get_count++;
                end
                OP_PUT:
                begin
                    rep.put_valid = 1'b1;
                    rep.put_value = acc;
                    put_count++;
                end
                OP_LD, OP_ST, OP_ADD, OP_SUB:
                begin
                    if (opnd >= MEM_WORDS)
                    begin
                        halt(FLT_RANGE);
                        return;
                    end
                    case (opcode_t'(op_word[3:0]))
                        OP_LD:   acc = mem[opnd];
                        OP_ST:   mem[opnd] = acc;
                        OP_ADD:  acc = acc + mem[opnd];
                        default: acc = acc - mem[opnd];
                    endcase
                end
                default:
                begin
                    case (opcode_t'(op_word[3:0]))
                        OP_JPOS: taken = !acc[63] && acc != '0;
                        OP_JZ:   taken = acc == '0;
                        default: taken = 1'b1;
                    endcase
                    if (taken)
                    begin
                        if (opnd[63])
                        begin
                            halt(FLT_NONE);
                            return;
                        end
                        if (opnd >= MEM_WORDS)
                        begin
                            halt(FLT_RANGE);
                            return;
                        end
                        pc = opnd;
                        return;
                    end
                end
            endcase
            // running off the end: full effect, then halt in place
            if (seq_pc >= MEM_WORDS)
            begin
                halt(FLT_RANGE);
                return;
            end
            pc = seq_pc;
        endfunction

        function void note_request(req_t req, logic [11:0] waddr, logic [63:0] wdata,
                                   logic [31:0] ival, bit eof);
            step_report_t rep;
            rep = '0;
            if (req == REQ_WRITE || req == REQ_RESTART || (req == REQ_EXEC && !stopped))
                useful_requests++;
            case (req)
                REQ_WRITE:
                begin
                    write_count++;
                    if (waddr < MEM_WORDS)
                        mem[waddr] = wdata;
                end
                REQ_EXEC:
                begin
                    if (!stopped)
                        execute_instruction({{32{ival[31]}}, ival}, eof, rep);
                end
                REQ_RESTART:
                begin
                    restart_count++;
                    pc = '0;
                    acc = '0;
                    stopped = 1'b0;
                    fault_code = FLT_NONE;
                end
                default: ;
            endcase
            rep.halted = stopped;
            rep.fault = fault_code;
            rep.pc_now = pc[11:0];
            rep.acc_now = acc;
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%h, got 0x%h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            step_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("put_valid", 64'(want.put_valid), 64'(tuser[0]));
            compare_field("took_input", 64'(want.took_input), 64'(tuser[1]));
            compare_field("halted", 64'(want.halted), 64'(tuser[2]));
            compare_field("fault", 64'(want.fault), 64'(tuser[4:3]));
            compare_field("put_value", want.put_value, tdata[63:0]);
            compare_field("pc_now", 64'(want.pc_now), 64'(tdata[75:64]));
            compare_field("acc_now", want.acc_now, tdata[139:76]);
        endfunction

        function void closing_check();
            if (pending_reports.size() != 0)
            begin
                $error("%0d result beats never arrived", pending_reports.size());
                errors++;
            end
        endfunction
    endclass

endpackage

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;
    import acm_check_pkg::*;

    localparam int PHASE_ITEMS   = 450;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DATA_BASE     = 64;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    int unsigned tx_idle_pct = 9;
    int unsigned rx_idle_pct = 78;
    int unsigned cycle_count = 0;
    acm_tracker  tracker;

    accumulator_machine_core #(
        .MEM_WORDS(MEM_WORDS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[accumulator_machine_core] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(req_t req, logic [11:0] waddr, logic [63:0] wdata,
                                logic [31:0] ival, bit eof);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({ival, wdata, waddr});
        s_axis_tuser  <= {eof, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_request(req, waddr, wdata, ival, eof);
    endtask

    task automatic write_word(logic [11:0] waddr, logic [63:0] wdata);
        send_request(REQ_WRITE, waddr, wdata, $urandom, 1'($urandom));
    endtask

    task automatic step(logic [31:0] ival, bit eof);
        send_request(REQ_EXEC, 12'($urandom), rand64(), ival, eof);
    endtask

    task automatic restart_machine();
        send_request(REQ_RESTART, 12'($urandom), rand64(), $urandom, 1'($urandom));
    endtask

    // Hold the input side low until every outstanding result beat is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_opcode();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return 64'(OP_STOP);
        if (r < 6)
            return 64'(OP_JMP) + 64'($urandom_range(1, 6));
        if (r < 8)
            return rand64();
        return 64'($urandom_range(OP_GET, OP_JMP));
    endfunction

    function automatic logic [63:0] pick_operand(logic [63:0] op_word, int unsigned prog_len);
        int unsigned r;
        r = $urandom_range(99);
        if (op_word >= 64'(OP_LD) && op_word <= 64'(OP_SUB))
        begin
            if (r < 75)
                return 64'(DATA_BASE + $urandom_range(0, 7));
            if (r < 85)
                return 64'(12'($urandom));
            if (r < 90)
                return 64'(MEM_WORDS - 1);
            if (r < 95)
                return 64'(MEM_WORDS) + 64'($urandom_range(0, 100));
            return {1'b1, 63'(rand64())};
        end
        if (op_word >= 64'(OP_JPOS) && op_word <= 64'(OP_JMP))
        begin
            if (r < 75)
                return 64'(2 * $urandom_range(0, prog_len - 1));
            if (r < 80)
                return 64'(2 * $urandom_range(0, prog_len - 1) + 1);
            if (r < 87)
                return 64'(MEM_WORDS - $urandom_range(1, 2));
            if (r < 93)
                return {1'b1, 63'(rand64())};
            if (r < 97)
                return 64'(MEM_WORDS) + 64'($urandom_range(0, 100));
            return {1'b0, 63'(rand64())};
        end
        return rand64();
    endfunction

    function automatic logic [63:0] pick_data();
        case ($urandom_range(7))
            0: return 64'h7fff_ffff_ffff_ffff;
            1: return 64'h8000_0000_0000_0000;
            2: return '0;
            3: return 64'($signed($urandom_range(0, 40)) - 20);
            default: return rand64();
        endcase
    endfunction

    function automatic logic [31:0] pick_get_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4: return 32'($signed($urandom_range(0, 10)) - 5);
            default: return $urandom;
        endcase
    endfunction

    // Load a short program, a few data words, then step it with some noise mixed in
    task automatic run_program(int unsigned prog_len, bit with_restart);
        logic [63:0] op_word;
        int unsigned steps;
        int unsigned r;
        if (with_restart)
            restart_machine();
        for (int unsigned i = 0; i < prog_len; i++)
        begin
            op_word = pick_opcode();
            write_word(12'(2 * i), op_word);
            write_word(12'(2 * i + 1), pick_operand(op_word, prog_len));
        end
        // code in the last two words exercises running off the end
        if ($urandom_range(3) == 0)
        begin
            op_word = pick_opcode();
            write_word(12'(MEM_WORDS - 2), op_word);
            if ($urandom_range(1) == 0)
                write_word(12'(MEM_WORDS - 1), pick_operand(op_word, prog_len));
            else
                write_word(12'(MEM_WORDS - 1), pick_opcode());
        end
        repeat ($urandom_range(1, 4))
            write_word(12'(DATA_BASE + $urandom_range(0, 7)), pick_data());
        steps = $urandom_range(prog_len, 4 * prog_len);
        for (int unsigned s = 0; s < steps && !tracker.stopped; s++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                write_word(12'($urandom), rand64());
            else if (r < 6)
                send_request(REQ_NONE, 12'($urandom), rand64(), $urandom, 1'($urandom));
            else if (r < 7)
                restart_machine();
            step(pick_get_value(), $urandom_range(19) == 0);
        end
        if (tracker.stopped && $urandom_range(2) == 0)
            step(pick_get_value(), 1'($urandom));
    endtask

    task automatic run_directed();
        step('0, 1'b0);
        send_request(REQ_NONE, '1, '1, '1, 1'b1);
        restart_machine();
        write_word(12'd0, 64'(OP_GET));
        write_word(12'd2, 64'(OP_ADD));
        write_word(12'd3, 64'(MEM_WORDS - 1));
        write_word(12'(MEM_WORDS - 1), 64'h7fff_ffff_ffff_ffff);
        write_word(12'd4, 64'(OP_PUT));
        write_word(12'd6, 64'(OP_SUB));
        write_word(12'd8, 64'(OP_JPOS));
        write_word(12'd9, 64'd12);
        write_word(12'd12, 64'(OP_JZ));
        write_word(12'd14, 64'(OP_ST));
        write_word(12'd16, 64'(OP_LD));
        write_word(12'd17, 64'(MEM_WORDS - 1));
        write_word(12'd18, 64'(OP_JMP));
        write_word(12'd19, 64'h8000_0000_0000_0000);
        // get, add, put, sub, taken jpos, untaken jz, st, ld, jump to a negative address
        repeat (9)
            step(32'h8000_0000, 1'b0);
        step(32'h7fff_ffff, 1'b1);
        // the stored accumulator now sits in word 0 as an illegal opcode
        restart_machine();
        step(32'h7fff_ffff, 1'b0);
        restart_machine();
        write_word(12'd0, 64'(OP_GET));
        step(32'h7fff_ffff, 1'b1);
    endtask

    initial
    begin
        int unsigned goal;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct <= 9;
                    rx_idle_pct <= 78;
                end
                1:
                begin
                    tx_idle_pct <= 78;
                    rx_idle_pct <= 9;
                end
                default:
                begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            if (phase == 0)
                run_directed();
            goal = tracker.useful_requests + PHASE_ITEMS;
            while (tracker.useful_requests < goal)
            begin
                run_program($urandom_range(3, 8), $urandom_range(7) != 0);
                if ($urandom_range(9) == 0)
                    drain_results();
            end
            drain_results();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.closing_check();
        $display("covered %0d writes, %0d restarts, %0d instructions (%0d puts, %0d gets)",
                 tracker.write_count, tracker.restart_count, tracker.instr_count,
                 tracker.put_count, tracker.get_count);
        $display("halts: %0d plain, %0d illegal opcode, %0d address range; %0d mismatches",
                 tracker.halt_count[FLT_NONE], tracker.halt_count[FLT_OPCODE],
                 tracker.halt_count[FLT_RANGE], tracker.errors);
        if (tracker.errors == 0)
            $display("[accumulator_machine_core] OK");
        else
            $display("[accumulator_machine_core] ERROR");
        $finish;
    end

endmodule
